>>> src/galois_field_multiply_assert.svh
// ----------------------------------------------------------------------------
// Galois field multiplier assertion macros
// Shared forms for the concurrent checks of the multiplier. They expect clk
// and rst_n in the scope where they are used.
// ----------------------------------------------------------------------------
`ifndef GALOIS_FIELD_MULTIPLY_ASSERT_SVH
`define GALOIS_FIELD_MULTIPLY_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GFM_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("galois_field_multiply: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define GFM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("galois_field_multiply: next-cycle check failed");

`endif

>>> src/gfm_pkg.sv
// ----------------------------------------------------------------------------
// Galois field multiplier package
// Widths, reset values, register indexes and shared types of the multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

package gfm_pkg;

    localparam int OPERAND_W   = 8;
    localparam int POLY_W      = 15;
    localparam int MOD_W       = 9;
    localparam int DEG_W       = 4;
    localparam int CFG_DATA_W  = 9;
    localparam int CFG_INDEX_W = 1;

    localparam logic [MOD_W-1:0] MODULUS_RESET = 9'd283;
    localparam logic [DEG_W-1:0] DEGREE_RESET  = 4'd8;
    localparam logic [DEG_W-1:0] DEGREE_MIN    = 4'd1;
    localparam logic [DEG_W-1:0] DEGREE_MAX    = 4'd8;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MODULUS      = 1'b0,
        CFG_FIELD_DEGREE = 1'b1
    } cfg_index_t;

    typedef logic [POLY_W-1:0] poly_t;

    // Modulus shifted so that its leading term sits at bit 8, with the degree.
    typedef struct packed {
        logic [MOD_W-1:0] mod_norm;
        logic [DEG_W-1:0] degree;
    } field_cfg_t;

endpackage

`default_nettype wire

>>> src/gfm_in_if.sv
// ----------------------------------------------------------------------------
// Galois field multiplier operand channel
// Valid/ready channel that carries one pair of field elements per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface gfm_in_if
    import gfm_pkg::*;
();

    logic                 valid;
    logic                 ready;
    logic [OPERAND_W-1:0] operand_a;
    logic [OPERAND_W-1:0] operand_b;

    modport source (output valid, output operand_a, output operand_b, input ready);
    modport sink   (input valid, input operand_a, input operand_b, output ready);

endinterface

`default_nettype wire

>>> src/gfm_out_if.sv
// ----------------------------------------------------------------------------
// Galois field multiplier result channel
// Valid/ready channel that carries one reduced product and its error flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface gfm_out_if
    import gfm_pkg::*;
();

    logic                 valid;
    logic                 ready;
    logic [OPERAND_W-1:0] product;
    logic                 bad_modulus;

    modport source (output valid, output product, output bad_modulus, input ready);
    modport sink   (input valid, input product, input bad_modulus, output ready);

endinterface

`default_nettype wire

>>> src/gfm_reduce.sv
// ----------------------------------------------------------------------------
// Galois field multiplier reduction slice
// Clears polynomial bits HI down to LO that lie at or above the field degree
// by adding shifted copies of the normalized modulus.
// ----------------------------------------------------------------------------
`default_nettype none

module gfm_reduce
    import gfm_pkg::*;
#(
    parameter int HI = 14,
    parameter int LO = 8
) (
    input  field_cfg_t cfg,
    input  poly_t      poly_in,
    output poly_t      poly_out
);

    poly_t poly_work;

    always_comb
    begin
        poly_work = poly_in;
        for (int i = HI; i >= LO; i--)
        begin
            if ((DEG_W'(i) >= cfg.degree) && poly_work[i])
            begin
                if (i >= OPERAND_W)
                begin
                    poly_work = poly_work ^ (POLY_W'(cfg.mod_norm) << (i - OPERAND_W));
                end
                else
                begin
                    poly_work = poly_work ^ POLY_W'(cfg.mod_norm >> (OPERAND_W - i));
                end
            end
        end
    end

    assign poly_out = poly_work;

endmodule

`default_nettype wire

>>> src/galois_field_multiply.sv
// ----------------------------------------------------------------------------
// Galois field multiplier
// Multiplies two bytes in GF(2^d) under a configurable modulus polynomial.
//
// Operand words arrive on a valid/ready channel and reduced products leave on
// another; both move a word at a rising edge where valid and ready are high.
// The modulus and field degree are set through a plain write port and must be
// written only while no word is in flight. A word passes three register
// stages: a carry-less multiply stage, a stage that clears product bits 14 to
// 8, and a stage that clears bits 7 to 1 and holds the result. It shows as a
// valid result once it reaches the result stage and can leave from there. One
// word enters and one leaves every cycle while the receiver takes them. When
// the receiver stalls, the stages fill up behind the result register and the
// operand channel drops ready once all three are occupied; nothing is lost or
// repeated. Reset empties the pipeline and selects the AES field, modulus
// 0x11B of degree 8. A modulus whose leading term is not at the configured
// degree, or a degree outside 1 to 8, gives a product of zero with
// bad_modulus set.
// ----------------------------------------------------------------------------
`default_nettype none

module galois_field_multiply
    import gfm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    gfm_in_if.sink                 operands,
    gfm_out_if.source              result
);

    logic [MOD_W-1:0] modulus_reg;
    logic [DEG_W-1:0] field_degree_reg;

    logic       degree_ok;
    logic       lead_ok;
    logic       mod_ok;
    logic [2:0] norm_shift;
    field_cfg_t field_cfg;

    logic                 s1_valid_reg;
    poly_t                s1_poly_reg;
    logic                 s1_bad_reg;
    logic                 s2_valid_reg;
    poly_t                s2_poly_reg;
    logic                 s2_bad_reg;
    logic                 s3_valid_reg;
    logic [OPERAND_W-1:0] s3_product_reg;
    logic                 s3_bad_reg;

    poly_t                s1_poly_next;
    poly_t                s2_poly_next;
    poly_t                s3_poly_full;
    logic [OPERAND_W-1:0] s3_product_next;

    logic s1_ready;
    logic s2_ready;
    logic s3_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg      <= MODULUS_RESET;
            field_degree_reg <= DEGREE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_MODULUS:      modulus_reg      <= cfg_data[MOD_W-1:0];
                CFG_FIELD_DEGREE: field_degree_reg <= cfg_data[DEG_W-1:0];
                default:          ;
            endcase
        end
    end

    assign degree_ok = field_degree_reg inside {[DEGREE_MIN:DEGREE_MAX]};
    assign lead_ok   = (modulus_reg >> field_degree_reg) == MOD_W'(1);
    assign mod_ok    = degree_ok && lead_ok;

    assign norm_shift         = 3'(DEG_W'(OPERAND_W) - field_degree_reg);
    assign field_cfg.mod_norm = modulus_reg << norm_shift;
    assign field_cfg.degree   = field_degree_reg;

    always_comb
    begin
        s1_poly_next = '0;
        for (int k = 0; k < OPERAND_W; k++)
        begin
            if (operands.operand_b[k])
            begin
                s1_poly_next = s1_poly_next ^ (POLY_W'(operands.operand_a) << k);
            end
        end
    end

    gfm_reduce #(
        .HI (POLY_W - 1),
        .LO (OPERAND_W)
    ) u_reduce_hi (
        .cfg      (field_cfg),
        .poly_in  (s1_poly_reg),
        .poly_out (s2_poly_next)
    );

    gfm_reduce #(
        .HI (OPERAND_W - 1),
        .LO (1)
    ) u_reduce_lo (
        .cfg      (field_cfg),
        .poly_in  (s2_poly_reg),
        .poly_out (s3_poly_full)
    );

    assign s3_product_next = s2_bad_reg ? '0 : s3_poly_full[OPERAND_W-1:0];

    assign s3_ready = !s3_valid_reg || result.ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;

    assign operands.ready = s1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= operands.valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && operands.valid)
        begin
            s1_poly_reg <= s1_poly_next;
            s1_bad_reg  <= !mod_ok;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_poly_reg <= s2_poly_next;
            s2_bad_reg  <= s1_bad_reg;
        end
        if (s3_ready && s2_valid_reg)
        begin
            s3_product_reg <= s3_product_next;
            s3_bad_reg     <= s2_bad_reg;
        end
    end

    assign result.valid       = s3_valid_reg;
    assign result.product     = s3_product_reg;
    assign result.bad_modulus = s3_bad_reg;

`include "galois_field_multiply_assert.svh"

    `GFM_ASSERT_SAME(a_bad_gives_zero, result.valid && result.bad_modulus, result.product == '0)
    `GFM_ASSERT_SAME(a_full_blocks_input,
        result.valid && !result.ready && s1_valid_reg && s2_valid_reg, !operands.ready)
    `GFM_ASSERT_NEXT(a_bad_flag_enters,
        operands.valid && operands.ready && !mod_ok, s1_valid_reg && s1_bad_reg)

endmodule

`default_nettype wire
